[rtl/sha1_pkg.sv]
// SHA-1 hasher package: constants, command types and round functions.
// Used by sha1_ctrl, sha1_dp and sha1_message_hasher; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sha1_pkg;

  localparam int WORD_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int FILL_W  = 6;
  localparam int TOTAL_W = 61;
  localparam int LEN_W   = 64;
  localparam int RND_W   = 7;
  localparam int SCHED_N = 16;
  localparam int DIG_W   = 5 * WORD_W;

  localparam logic [FILL_W-1:0] FILL_FULL = 6'd63;
  localparam logic [FILL_W-1:0] FILL_LEN  = 6'd56;
  localparam logic [RND_W-1:0]  RND_LAST  = 7'd79;

  localparam logic [WORD_W-1:0] H0_INIT = 32'h67452301;
  localparam logic [WORD_W-1:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [WORD_W-1:0] H2_INIT = 32'h98BADCFE;
  localparam logic [WORD_W-1:0] H3_INIT = 32'h10325476;
  localparam logic [WORD_W-1:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

  localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_ROUND = 6'b000100,
    ST_ADD   = 6'b001000,
    ST_OUT   = 6'b010000,
    ST_SPARE = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_IN,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  typedef struct packed {
    byte_src_t        push_sel;
    logic             load_work;
    logic             round_en;
    logic [RND_W-1:0] rnd;
    logic             add_chain;
    logic             out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
  } dp_stat_t;

  function automatic logic [WORD_W-1:0] round_k(input logic [RND_W-1:0] rnd);
    logic [WORD_W-1:0] k;
    if (rnd < 7'd20)      k = K0;
    else if (rnd < 7'd40) k = K1;
    else if (rnd < 7'd60) k = K2;
    else                  k = K3;
    return k;
  endfunction

  function automatic logic [WORD_W-1:0] round_f(input logic [RND_W-1:0]  rnd,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic [WORD_W-1:0] c,
                                                 input logic [WORD_W-1:0] d);
    logic [WORD_W-1:0] f;
    if (rnd < 7'd20)      f = (b & c) | (~b & d);
    else if (rnd < 7'd40) f = b ^ c ^ d;
    else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
    else                  f = b ^ c ^ d;
    return f;
  endfunction

endpackage

`default_nettype wire

[rtl/sha1_dp.sv]
// SHA-1 datapath: byte packer, 16-word schedule shift line, round engine,
// chain words, byte counter and digest output register. Uses sha1_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha1_dp
  import sha1_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dp_cmd_t           cmd,
  input  wire logic [BYTE_W-1:0] in_byte,
  output dp_stat_t               stat,
  output logic [DIG_W-1:0]       digest
);

  logic [WORD_W-1:0]  w_r [SCHED_N];
  logic [23:0]        acc_r;
  logic [FILL_W-1:0]  fill_r;
  logic [TOTAL_W-1:0] total_r;
  logic [WORD_W-1:0]  h_r [5];
  logic [WORD_W-1:0]  a_r, b_r, c_r, d_r, e_r;
  logic [DIG_W-1:0]   dig_r;

  logic [BYTE_W-1:0]  pbyte;
  logic [LEN_W-1:0]   len_bits;
  logic [LEN_W-1:0]   len_sh;
  logic               push;
  logic               word_done;
  logic [WORD_W-1:0]  sched_new;
  logic [WORD_W-1:0]  wx;
  logic [WORD_W-1:0]  temp;

  assign len_bits = {total_r, 3'b000};
  assign len_sh   = len_bits << {fill_r[2:0], 3'b000};
  assign push     = (cmd.push_sel != SRC_NONE);

  always_comb begin
    unique case (cmd.push_sel)
      SRC_IN:   pbyte = in_byte;
      SRC_MARK: pbyte = PAD_MARK;
      SRC_LEN:  pbyte = len_sh[LEN_W-1 -: BYTE_W];
      default:  pbyte = '0;
    endcase
  end

  assign word_done = push && (fill_r[1:0] == 2'b11);
  assign wx        = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign sched_new = cmd.round_en ? {wx[WORD_W-2:0], wx[WORD_W-1]} : {acc_r, pbyte};
  assign temp      = {a_r[WORD_W-6:0], a_r[WORD_W-1 -: 5]}
                   + round_f(cmd.rnd, b_r, c_r, d_r) + e_r + round_k(cmd.rnd) + w_r[0];

  always_ff @(posedge clk) begin
    if (word_done || cmd.round_en) begin
      for (int i = 0; i < SCHED_N - 1; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[SCHED_N-1] <= sched_new;
    end
    if (push) begin
      acc_r <= {acc_r[15:0], pbyte};
    end
    if (cmd.load_work) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (cmd.round_en) begin
      a_r <= temp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[WORD_W-1:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
    if (cmd.out_load) begin
      dig_r <= {h_r[4], h_r[3], h_r[2], h_r[1], h_r[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      total_r <= '0;
      h_r[0]  <= H0_INIT;
      h_r[1]  <= H1_INIT;
      h_r[2]  <= H2_INIT;
      h_r[3]  <= H3_INIT;
      h_r[4]  <= H4_INIT;
    end else begin
      if (push) begin
        fill_r <= fill_r + 1'b1;
      end
      if (cmd.out_load) begin
        total_r <= '0;
      end else if (cmd.push_sel == SRC_IN) begin
        total_r <= total_r + 1'b1;
      end
      if (cmd.out_load) begin
        h_r[0] <= H0_INIT;
        h_r[1] <= H1_INIT;
        h_r[2] <= H2_INIT;
        h_r[3] <= H3_INIT;
        h_r[4] <= H4_INIT;
      end else if (cmd.add_chain) begin
        h_r[0] <= h_r[0] + a_r;
        h_r[1] <= h_r[1] + b_r;
        h_r[2] <= h_r[2] + c_r;
        h_r[3] <= h_r[3] + d_r;
        h_r[4] <= h_r[4] + e_r;
      end
    end
  end

  assign stat.fill = fill_r;
  assign digest    = dig_r;

endmodule

`default_nettype wire

[rtl/sha1_ctrl.sv]
// SHA-1 controller: sequences byte intake, padding, 80 rounds per block
// and digest hand-off. Uses sha1_pkg; drives sha1_dp through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module sha1_ctrl
  import sha1_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire logic     in_byte_valid,
  input  wire logic     in_last,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t           state_r, state_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic             pad_act_r, pad_act_nxt;
  logic             mark_r, mark_nxt;
  logic             len_ok_r, len_ok_nxt;
  logic             final_r, final_nxt;
  logic             oval_r, oval_nxt;
  logic             full;

  assign full = (stat.fill == FILL_FULL);

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    pad_act_nxt   = pad_act_r;
    mark_nxt      = mark_r;
    len_ok_nxt    = len_ok_r;
    final_nxt     = final_r;
    oval_nxt      = oval_r && !out_tready;
    cmd           = '0;
    cmd.push_sel  = SRC_NONE;
    cmd.rnd       = rnd_r;
    in_tready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          pad_act_nxt = in_last;
          if (in_byte_valid) begin
            cmd.push_sel = SRC_IN;
          end
          if (in_byte_valid && full) begin
            cmd.load_work = 1'b1;
            rnd_nxt       = '0;
            state_nxt     = ST_ROUND;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        mark_nxt = 1'b1;
        if (!mark_r) begin
          cmd.push_sel = SRC_MARK;
          len_ok_nxt   = (stat.fill < FILL_LEN);
        end else if (len_ok_r && stat.fill >= FILL_LEN) begin
          cmd.push_sel = SRC_LEN;
        end else begin
          cmd.push_sel = SRC_ZERO;
        end
        if (full) begin
          final_nxt     = (cmd.push_sel == SRC_LEN);
          len_ok_nxt    = 1'b1;
          cmd.load_work = 1'b1;
          rnd_nxt       = '0;
          state_nxt     = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_nxt      = rnd_r + 1'b1;
        if (rnd_r == RND_LAST) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add_chain = 1'b1;
        if (final_r) begin
          state_nxt = ST_OUT;
        end else if (pad_act_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!oval_r || out_tready) begin
          cmd.out_load = 1'b1;
          oval_nxt     = 1'b1;
          pad_act_nxt  = 1'b0;
          mark_nxt     = 1'b0;
          len_ok_nxt   = 1'b0;
          final_nxt    = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rnd_r     <= '0;
      pad_act_r <= 1'b0;
      mark_r    <= 1'b0;
      len_ok_r  <= 1'b0;
      final_r   <= 1'b0;
      oval_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rnd_r     <= rnd_nxt;
      pad_act_r <= pad_act_nxt;
      mark_r    <= mark_nxt;
      len_ok_r  <= len_ok_nxt;
      final_r   <= final_nxt;
      oval_r    <= oval_nxt;
    end
  end

  assign out_tvalid = oval_r;

endmodule

`default_nettype wire

[rtl/sha1_message_hasher.sv]
// SHA-1 message hasher top: byte stream in, 160-bit digest beat out.
// A beat is taken while idle; the 64th byte of a block starts 80 rounds and then the chain add.
// Last beat: pad one byte per cycle (up to 72), pausing to compress each full block,
// then load the output register once any held digest is taken. No input is taken during rounds.
// Synchronous active-low reset restores the initial chain and clears counts; no clearing pass.
// Instantiates sha1_ctrl and sha1_dp; uses sha1_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha1_message_hasher
  import sha1_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [BYTE_W-1:0] in_tdata,   // [7:0] data_byte
  input  wire logic              in_tuser,   // [0] byte_valid
  input  wire logic              in_tlast,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [DIG_W-1:0]       out_tdata   // digest_e, digest_d, ... digest_a from the MSB down, 32 bits each
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sha1_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_byte_valid (in_tuser),
    .in_last       (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  sha1_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_byte (in_tdata),
    .stat    (stat),
    .digest  (out_tdata)
  );

endmodule

`default_nettype wire

[tb/sha1_message_hasher_test.sv]
// Testbench for sha1_message_hasher: streams message bytes and checks every digest beat
// against a SHA-1 predictor kept in this file or a fixed known digest. Depends on sha1_pkg and the RTL only.
`timescale 1ns / 1ps

module sha1_message_hasher_test;
  import sha1_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
    logic [WORD_W-1:0] e;
  } digest_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              valid;
    logic              last;
    logic              typed;
    digest_t           want;
  } stim_row_t;

  typedef enum int {
    MODE_FREE,
    MODE_SRC_GAPS,
    MODE_SINK_STALLS,
    MODE_BOTH
  } traffic_mode_t;

  localparam int ITEMS_TARGET = 1050;
  localparam int MODE_SPAN    = 263;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 400;

  localparam digest_t NO_DIGEST    = '0;
  localparam digest_t EMPTY_DIGEST = {32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef,
                                      32'h95601890, 32'hafd80709};
  localparam digest_t ABC_DIGEST   = {32'ha9993e36, 32'h4706816a, 32'hba3e2571,
                                      32'h7850c26c, 32'h9cd0d89d};

  localparam int N_DIRECTED = 15;
  // data, byte_valid, last, typed, expected digest
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},     // idle
    '{8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message
    '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},     // idle inside a message
    '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},    // byte rides with last
    '{8'hFF, 1'b1, 1'b1, 1'b0, NO_DIGEST},
    '{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'hA5, 1'b0, 1'b0, 1'b0, NO_DIGEST},     // data ignored
    '{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
    '{8'h5A, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'hA5, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h00, 1'b0, 1'b1, 1'b0, NO_DIGEST},     // last without a byte
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
    '{8'h80, 1'b1, 1'b1, 1'b0, NO_DIGEST}
  };

  localparam int BOUNDARY_LENS [9] = '{55, 56, 57, 62, 63, 64, 65, 119, 120};

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata;
  logic              in_tuser;
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DIG_W-1:0]  out_tdata;

  traffic_mode_t mode;
  digest_t       pending_digests [$];
  int            errors = 0;
  int            items_sent = 0;
  int            bytes_hashed = 0;
  int            digests_queued = 0;
  int            digests_checked = 0;
  int            stall_cycles = 0;

  // predictor state
  logic [WORD_W-1:0]  chain_h [5];
  logic [TOTAL_W-1:0] msg_len_bytes;
  logic [WORD_W-1:0]  blk_words [16];
  int                 blk_fill;

  sha1_message_hasher uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #2 clk = ~clk;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

  task automatic restart_chain();
    chain_h[0] = 32'h67452301;
    chain_h[1] = 32'hEFCDAB89;
    chain_h[2] = 32'h98BADCFE;
    chain_h[3] = 32'h10325476;
    chain_h[4] = 32'hC3D2E1F0;
    msg_len_bytes = '0;
    blk_fill = 0;
  endtask

  task automatic compress_block();
    logic [WORD_W-1:0] w [16];
    logic [WORD_W-1:0] a, b, c, d, e, f, k, t;
    w = blk_words;
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16)
        w[r % 16] = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16], 1);
      if (r < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;          k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;          k = 32'hCA62C1D6;
      end
      t = rotl(a, 5) + f + e + k + w[r % 16];
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
  endtask

  // big-endian placement; the first byte of a word clears the rest of it
  task automatic place_byte(input int pos, input logic [BYTE_W-1:0] v);
    if (pos % 4 == 0) blk_words[pos / 4] = {v, 24'h0};
    else blk_words[pos / 4] |= WORD_W'(v) << ((3 - pos % 4) * 8);
  endtask

  task automatic absorb_beat(input logic [BYTE_W-1:0] b, input logic v, input logic l,
                             output logic done, output digest_t dg);
    int                pos;
    logic [LEN_W-1:0]  bits;
    done = 1'b0;
    dg = NO_DIGEST;
    if (v) begin
      place_byte(blk_fill, b);
      msg_len_bytes = msg_len_bytes + 1'b1;
      blk_fill = (blk_fill + 1) % 64;
      if (blk_fill == 0) compress_block();
    end
    if (l) begin
      place_byte(blk_fill, 8'h80);
      pos = blk_fill + 1;
      if (pos > 56) begin
        for (int i = (pos + 3) / 4; i < 16; i++) blk_words[i] = '0;
        compress_block();
        pos = 0;
      end
      for (int i = (pos + 3) / 4; i < 14; i++) blk_words[i] = '0;
      bits = {msg_len_bytes, 3'b000};
      blk_words[14] = bits[63:32];
      blk_words[15] = bits[31:0];
      compress_block();
      dg = {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
      done = 1'b1;
      restart_chain();
    end
  endtask

  function automatic int send_gap_pct();
    case (mode)
      MODE_SRC_GAPS: return 46;
      MODE_BOTH:     return 12;
      default:       return 0;
    endcase
  endfunction

  function automatic int sink_stall_pct();
    case (mode)
      MODE_SINK_STALLS: return 46;
      MODE_BOTH:        return 12;
      default:          return 0;
    endcase
  endfunction

  // called just after a falling edge; returns just after the falling edge that follows the beat
  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic v, input logic l,
                           input logic typed, input digest_t want);
    logic    done;
    digest_t dg;
    while ($urandom_range(99) < send_gap_pct()) begin
      in_tvalid <= 1'b0;
      in_tdata  <= BYTE_W'($urandom);
      in_tuser  <= 1'($urandom);
      in_tlast  <= 1'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= v;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    absorb_beat(b, v, l, done, dg);
    if (v) bytes_hashed++;
    items_sent++;
    if (done) begin
      pending_digests.push_back(typed ? want : dg);
      digests_queued++;
    end
    @(negedge clk);
  endtask

  task automatic random_message();
    int   len;
    int   pick;
    logic tail_byte;
    pick = $urandom_range(99);
    if (pick < 55) len = $urandom_range(16);
    else if (pick < 80) len = BOUNDARY_LENS[$urandom_range(8)];
    else len = $urandom_range(140, 17);
    tail_byte = (len != 0) && ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 6) send_beat(BYTE_W'($urandom), 1'b0, 1'b0, 1'b0, NO_DIGEST);
      send_beat(BYTE_W'($urandom), 1'b1, tail_byte && (i == len - 1), 1'b0, NO_DIGEST);
    end
    if (!tail_byte) send_beat(BYTE_W'($urandom), 1'b0, 1'b1, 1'b0, NO_DIGEST);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct());
  end

  always @(posedge clk) begin : check_digest
    digest_t           want;
    logic [WORD_W-1:0] exp_w;
    logic [WORD_W-1:0] act_w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_digests.size() == 0) begin
        errors++;
        $display("%0t: digest beat with none expected: expected none actual %h",
                 $time, out_tdata);
      end else begin
        want = pending_digests.pop_front();
        digests_checked++;
        for (int i = 0; i < 5; i++) begin
          exp_w = want[WORD_W * (4 - i) +: WORD_W];
          act_w = out_tdata[WORD_W * i +: WORD_W];
          if (exp_w !== act_w) begin
            errors++;
            $display("%0t: digest word %0d: expected %h actual %h", $time, i, exp_w, act_w);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int            mode_idx;
    traffic_mode_t next_mode;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    mode      = MODE_FREE;
    restart_chain();
    for (int i = 0; i < 16; i++) blk_words[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_beat(DIRECTED[i].data, DIRECTED[i].valid, DIRECTED[i].last,
                DIRECTED[i].typed, DIRECTED[i].want);

    while (items_sent < ITEMS_TARGET) begin
      mode_idx = items_sent / MODE_SPAN;
      if (mode_idx > 3) mode_idx = 3;
      next_mode = traffic_mode_t'(mode_idx);
      if (next_mode != mode) begin
        // hold the sender until the block has delivered everything owed
        in_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_digests.size() != 0) @(negedge clk);
        mode = next_mode;
      end
      random_message();
    end
    in_tvalid <= 1'b0;

    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Hashed %0d bytes over %0d input beats; %0d digests checked", bytes_hashed,
             items_sent, digests_checked);
    $display("Traffic ran free, with source gaps, with sink stalls and with both.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sha1_message_hasher.f]
rtl/sha1_pkg.sv
rtl/sha1_dp.sv
rtl/sha1_ctrl.sv
rtl/sha1_message_hasher.sv
tb/sha1_message_hasher_test.sv
